/* design/hlva_pkg.sv */
// ============================================================================
// Hough line vote accumulator package
// Shared types, constants and the constant functions that build the Q1.14
// cosine and sine table.
// ============================================================================
package hlva_pkg;

   localparam int OP_W         = 2;
   localparam int COORD_W      = 10;
   localparam int PIXEL_W      = 12;
   localparam int ANGLE_IDX_W  = 8;
   localparam int DIST_IDX_W   = 12;
   localparam int CELL_COUNT_W = 21;
   localparam int SCALED_W     = 12;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int THRESH_W     = 12;
   localparam int BIAS_W       = 12;
   localparam int INV_SCALE_W  = 16;
   localparam int TRIG_W       = 16;

   localparam int DEF_NUM_ANGLES  = 256;
   localparam int DEF_DIST_BINS   = 4096;
   localparam int DEF_MAX_DIM     = 1024;
   localparam int DEF_COUNT_WIDTH = 21;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [THRESH_W-1:0]    THRESH_RESET    = 12'd2048;
   localparam logic [BIAS_W-1:0]      BIAS_RESET      = 12'd1449;
   localparam logic [INV_SCALE_W-1:0] INV_SCALE_RESET = 16'd256;

   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint          ONE_Q30 = 64'sd1073741824;

   typedef enum logic [OP_W-1:0] {
      OP_VOTE  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_BIAS      = 2'd1,
      CSR_INV_SCALE = 2'd2,
      CSR_SPARE     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_VOTE,
      CMD_READ,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [COORD_W-1:0]       row;
      logic [COORD_W-1:0]       col;
      logic [ANGLE_IDX_W-1:0]   angle;
      logic [DIST_IDX_W-1:0]    distance;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic sweeping;
      logic busy;
   } back_status_type;

   typedef enum logic [2:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_VOTE,
      BK_DRAIN,
      BK_RD_ADDR,
      BK_RD_DATA,
      BK_DIVIDE,
      BK_RESULT
   } back_state_type;

   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic longint series(input longint unsigned phi, input int start);
      longint unsigned p2;
      longint unsigned term;
      longint unsigned den;
      longint          sum;
      p2   = (phi * phi) >> 30;
      term = (start != 0) ? phi : longint'(ONE_Q30);
      sum  = longint'(term);
      for (int k = 1; k <= 12; k++) begin
         den  = longint'(2 * k - 1 + start) * longint'(2 * k + start);
         term = udiv((term * p2) >> 30, den);
         if ((k % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      return sum;
   endfunction

   function automatic logic signed [TRIG_W-1:0] q30_to_q14(input longint v);
      longint c;
      longint unsigned r;
      c = v;
      if (c < 0) c = 0;
      if (c > ONE_Q30) c = ONE_Q30;
      r = (longint'(c) + 64'd32768) >> 16;
      return TRIG_W'(r);
   endfunction

endpackage

/* design/hlva_front.sv */
// ============================================================================
// Hough line vote accumulator front end
// Accepts request transactions, screens out votes that cast nothing and
// undefined operations, and forwards the rest as commands.
// ============================================================================
module hlva_front #(
   parameter int MAX_DIM = hlva_pkg::DEF_MAX_DIM
) (
   input  logic                            reset,
   input  logic                            req_accept,
   input  logic [hlva_pkg::OP_W-1:0]       req_op,
   input  logic [hlva_pkg::COORD_W-1:0]    req_row,
   input  logic [hlva_pkg::COORD_W-1:0]    req_col,
   input  logic [hlva_pkg::PIXEL_W-1:0]    req_pixel_value,
   input  logic [hlva_pkg::ANGLE_IDX_W-1:0] req_angle_index,
   input  logic [hlva_pkg::DIST_IDX_W-1:0] req_distance_index,
   input  logic [hlva_pkg::THRESH_W-1:0]   vote_threshold,
   output logic                            cmd_push,
   output hlva_pkg::cmd_type               cmd
);
   import hlva_pkg::*;

   logic votes;

   assign votes = (req_pixel_value >= vote_threshold)
                  && (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);

   always_comb begin
      cmd.row      = req_row;
      cmd.col      = req_col;
      cmd.angle    = req_angle_index;
      cmd.distance = req_distance_index;
      cmd.kind     = CMD_VOTE;
      cmd_push     = 1'b0;
      unique case (op_type'(req_op))
         OP_VOTE: begin
            cmd.kind = CMD_VOTE;
            cmd_push = req_accept && votes && !reset;
         end
         OP_READ: begin
            cmd.kind = CMD_READ;
            cmd_push = req_accept && !reset;
         end
         OP_CLEAR: begin
            cmd.kind = CMD_CLEAR;
            cmd_push = req_accept && !reset;
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

endmodule

/* design/hlva_queue.sv */
// ============================================================================
// Hough line vote accumulator command queue
// A short first-in first-out queue that decouples the front end from the
// vote and read engine.
// ============================================================================
module hlva_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hlva_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output hlva_pkg::cmd_type          pop_cmd,
   output hlva_pkg::queue_status_type status
);
   import hlva_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W+1)'(do_push) - (QUEUE_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/hlva_back.sv */
// ============================================================================
// Hough line vote accumulator engine
// Holds the vote store, runs the per-angle vote pipeline, the clearing sweep,
// cell reads with the iterative scaling divider, and the response register.
// ============================================================================
module hlva_back #(
   parameter int NUM_ANGLES  = hlva_pkg::DEF_NUM_ANGLES,
   parameter int DIST_BINS   = hlva_pkg::DEF_DIST_BINS,
   parameter int COUNT_WIDTH = hlva_pkg::DEF_COUNT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hlva_pkg::queue_status_type        q_status,
   input  hlva_pkg::cmd_type                 q_cmd,
   output logic                              q_pop,
   input  logic [hlva_pkg::BIAS_W-1:0]       distance_bias,
   input  logic [hlva_pkg::INV_SCALE_W-1:0]  inv_scale,
   output hlva_pkg::back_status_type         status,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [hlva_pkg::CELL_COUNT_W-1:0] rsp_cell_count,
   output logic [hlva_pkg::SCALED_W-1:0]     rsp_scaled_value,
   output logic [hlva_pkg::CELL_COUNT_W-1:0] rsp_peak_count
);
   import hlva_pkg::*;

   localparam int AW  = $clog2(NUM_ANGLES);
   localparam int BW  = $clog2(DIST_BINS);
   localparam int MW  = AW + BW;
   localparam int PW  = COORD_W + 1 + TRIG_W;
   localparam int DW  = PW + 3;
   localparam int TW  = DW + INV_SCALE_W + 1;
   localparam int NW  = COUNT_WIDTH + SCALED_W;
   localparam int SW  = $clog2(SCALED_W);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic signed [TRIG_W-1:0] cos_tab [NUM_ANGLES];
   logic signed [TRIG_W-1:0] sin_tab [NUM_ANGLES];

   for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_trig
      localparam bit UPPER = (2 * g) > NUM_ANGLES;
      localparam longint unsigned M = UPPER ? longint'(NUM_ANGLES - g) : longint'(g);
      localparam longint unsigned PHI = PI_Q30 * M / NUM_ANGLES;
      localparam logic signed [TRIG_W-1:0] CV = q30_to_q14(series(PHI, 0));
      localparam logic signed [TRIG_W-1:0] SV = q30_to_q14(series(PHI, 1));
      assign cos_tab[g] = UPPER ? -CV : CV;
      assign sin_tab[g] = SV;
   end

   logic [COUNT_WIDTH-1:0] mem [2**MW];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [MW-1:0]          mem_raddr, mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;
   logic                   mem_we;

   back_state_type          state_ff, state_in;
   logic [MW-1:0]           sw_ff, sw_in;
   logic [AW-1:0]           ang_ff, ang_in;
   logic [COORD_W-1:0]      row_ff, row_in, col_ff, col_in;
   logic [MW-1:0]           rd_addr_ff, rd_addr_in;
   logic                    rd_oor_ff, rd_oor_in;
   logic [COUNT_WIDTH-1:0]  peak_ff, peak_in;

   logic                    v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic [AW-1:0]           a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in;
   logic signed [PW-1:0]    pr1_ff, pr1_in, pc1_ff, pc1_in;
   logic signed [DW-1:0]    d2_ff, d2_in;
   logic signed [TW-1:0]    t3_ff, t3_in;
   logic [MW-1:0]           addr4_ff, addr4_in;
   logic [TW-23:0]          bin3;
   logic [COUNT_WIDTH-1:0]  bumped;

   logic [COUNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]           rem_ff, rem_in, dvs_ff, dvs_in;
   logic [SCALED_W-1:0]     quo_ff, quo_in;
   logic [SW-1:0]           step_ff, step_in;
   logic [COUNT_WIDTH-1:0]  rd_cnt;

   logic                    out_valid_ff, out_valid_in;
   logic [COUNT_WIDTH-1:0]  out_cnt_ff, out_cnt_in, out_peak_ff, out_peak_in;
   logic [SCALED_W-1:0]     out_scaled_ff, out_scaled_in;
   logic                    out_load;

   assign bin3   = t3_ff[TW-1:22];
   assign bumped = (rd_data_ff < COUNT_MAX) ? rd_data_ff + 1'b1 : rd_data_ff;
   assign rd_cnt = rd_oor_ff ? '0 : rd_data_ff;

   assign status.sweeping = (state_ff == BK_SWEEP);
   assign status.busy     = (state_ff != BK_IDLE);
   assign rsp_empty        = !out_valid_ff;
   assign rsp_cell_count   = CELL_COUNT_W'(out_cnt_ff);
   assign rsp_scaled_value = out_scaled_ff;
   assign rsp_peak_count   = CELL_COUNT_W'(out_peak_ff);

   always_comb begin
      state_in  = state_ff;
      sw_in     = sw_ff;
      ang_in    = ang_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      rd_addr_in = rd_addr_ff;
      rd_oor_in  = rd_oor_ff;
      peak_in   = peak_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      q_pop     = 1'b0;
      out_load  = 1'b0;
      mem_raddr = addr4_in;
      mem_we    = 1'b0;
      mem_waddr = addr4_ff;
      mem_wdata = bumped;

      v1_in  = 1'b0;
      a1_in  = ang_ff;
      pr1_in = $signed({1'b0, row_ff}) * cos_tab[ang_ff];
      pc1_in = $signed({1'b0, col_ff}) * sin_tab[ang_ff];
      v2_in  = v1_ff;
      a2_in  = a1_ff;
      d2_in  = DW'(pr1_ff) + DW'(pc1_ff)
               + $signed(DW'({distance_bias, 14'd0}));
      v3_in  = v2_ff;
      a3_in  = a2_ff;
      t3_in  = d2_ff * $signed({1'b0, inv_scale});
      v4_in  = v3_ff && !t3_ff[TW-1] && (32'(bin3) < DIST_BINS);
      addr4_in = {a3_ff, bin3[BW-1:0]};

      if (v4_ff) begin
         mem_we = 1'b1;
         if (bumped > peak_ff) begin
            peak_in = bumped;
         end
      end

      unique case (state_ff)
         BK_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sw_ff;
            mem_wdata = '0;
            sw_in     = sw_ff + 1'b1;
            if (sw_ff == '1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop      = 1'b1;
               row_in     = q_cmd.row;
               col_in     = q_cmd.col;
               ang_in     = '0;
               rd_addr_in = {AW'(q_cmd.angle), BW'(q_cmd.distance)};
               rd_oor_in  = !((32'(q_cmd.angle) < NUM_ANGLES)
                              && (32'(q_cmd.distance) < DIST_BINS));
               unique case (q_cmd.kind)
                  CMD_VOTE: state_in = BK_VOTE;
                  CMD_READ: state_in = BK_RD_ADDR;
                  CMD_CLEAR: begin
                     state_in = BK_SWEEP;
                     sw_in    = '0;
                     peak_in  = '0;
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_VOTE: begin
            v1_in  = 1'b1;
            ang_in = ang_ff + 1'b1;
            if (32'(ang_ff) == NUM_ANGLES - 1) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff && !v4_ff) begin
               state_in = BK_IDLE;
            end
         end
         BK_RD_ADDR: begin
            mem_raddr = rd_addr_ff;
            state_in  = BK_RD_DATA;
         end
         BK_RD_DATA: begin
            cnt_in  = rd_cnt;
            rem_in  = (NW'(rd_cnt) << SCALED_W) - NW'(rd_cnt);
            dvs_in  = NW'(peak_ff) << (SCALED_W - 1);
            quo_in  = '0;
            step_in = '0;
            state_in = (peak_ff == '0) ? BK_RESULT : BK_DIVIDE;
         end
         BK_DIVIDE: begin
            if (rem_ff >= dvs_ff) begin
               rem_in = rem_ff - dvs_ff;
               quo_in = {quo_ff[SCALED_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[SCALED_W-2:0], 1'b0};
            end
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff + 1'b1;
            if (32'(step_ff) == SCALED_W - 1) begin
               state_in = BK_RESULT;
            end
         end
         BK_RESULT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      out_valid_in  = out_load || (out_valid_ff && !rsp_pop);
      out_cnt_in    = out_load ? cnt_ff : out_cnt_ff;
      out_scaled_in = out_load ? quo_ff : out_scaled_ff;
      out_peak_in   = out_load ? peak_ff : out_peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SWEEP;
         sw_ff        <= '0;
         peak_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         peak_ff      <= peak_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff        <= ang_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      rd_addr_ff    <= rd_addr_in;
      rd_oor_ff     <= rd_oor_in;
      a1_ff         <= a1_in;
      a2_ff         <= a2_in;
      a3_ff         <= a3_in;
      pr1_ff        <= pr1_in;
      pc1_ff        <= pc1_in;
      d2_ff         <= d2_in;
      t3_ff         <= t3_in;
      addr4_ff      <= addr4_in;
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      out_cnt_ff    <= out_cnt_in;
      out_scaled_ff <= out_scaled_in;
      out_peak_ff   <= out_peak_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

/* design/hough_line_vote_accumulator_top.sv */
// ============================================================================
// Hough line vote accumulator
// Casts Hough line votes for bright pixels into an angle by distance store,
// and reads back cells with their count scaled against the peak count.
//
//   Channel    Handshake            Transaction
//   req_       push / full          one vote, read or clear command
//   rsp_       empty / pop          one read result
//   csr_       valid / ready        one register write, ready always high
//
// A vote that casts is taken from the queue, then makes one store
// read-modify-write per angle on the store's two ports, and then drains the
// vote pipeline. A read steps through its address and data states and the
// one-bit-a-cycle divider, which it skips when the peak count is zero.
// A clear, and the sweep after reset, write one cell a cycle over all
// 2**(clog2(NUM_ANGLES) + clog2(DIST_BINS)) cells, 1048576 by default;
// full stays high during a sweep. Up to four commands queue while one runs.
// A finished result waits in its own register; a second finished result holds
// the engine until the first is popped.
// ============================================================================
module hough_line_vote_accumulator_top #(
   parameter int NUM_ANGLES  = hlva_pkg::DEF_NUM_ANGLES,
   parameter int DIST_BINS   = hlva_pkg::DEF_DIST_BINS,
   parameter int MAX_DIM     = hlva_pkg::DEF_MAX_DIM,
   parameter int COUNT_WIDTH = hlva_pkg::DEF_COUNT_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [hlva_pkg::OP_W-1:0]          req_op,
   input  logic [hlva_pkg::COORD_W-1:0]       req_row,
   input  logic [hlva_pkg::COORD_W-1:0]       req_col,
   input  logic [hlva_pkg::PIXEL_W-1:0]       req_pixel_value,
   input  logic [hlva_pkg::ANGLE_IDX_W-1:0]   req_angle_index,
   input  logic [hlva_pkg::DIST_IDX_W-1:0]    req_distance_index,
   output logic                               empty,
   input  logic                               pop,
   output logic [hlva_pkg::CELL_COUNT_W-1:0]  rsp_cell_count,
   output logic [hlva_pkg::SCALED_W-1:0]      rsp_scaled_value,
   output logic [hlva_pkg::CELL_COUNT_W-1:0]  rsp_peak_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hlva_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hlva_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hlva_pkg::*;

   logic [THRESH_W-1:0]    threshold_ff;
   logic [BIAS_W-1:0]      bias_ff;
   logic [INV_SCALE_W-1:0] inv_scale_ff;
   logic                   cmd_push, q_pop, req_accept;
   cmd_type                front_cmd, q_cmd;
   queue_status_type       q_status;
   back_status_type        b_status;

   assign csr_ready  = 1'b1;
   assign full       = q_status.full || b_status.sweeping;
   assign req_accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         bias_ff      <= BIAS_RESET;
         inv_scale_ff <= INV_SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_BIAS:      bias_ff      <= csr_wdata[BIAS_W-1:0];
            CSR_INV_SCALE: inv_scale_ff <= csr_wdata[INV_SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   hlva_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .reset              (reset),
      .req_accept         (req_accept),
      .req_op             (req_op),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_pixel_value    (req_pixel_value),
      .req_angle_index    (req_angle_index),
      .req_distance_index (req_distance_index),
      .vote_threshold     (threshold_ff),
      .cmd_push           (cmd_push),
      .cmd                (front_cmd)
   );

   hlva_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .pop_cmd  (q_cmd),
      .status   (q_status)
   );

   hlva_back #(
      .NUM_ANGLES  (NUM_ANGLES),
      .DIST_BINS   (DIST_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop),
      .distance_bias    (bias_ff),
      .inv_scale        (inv_scale_ff),
      .status           (b_status),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_cell_count   (rsp_cell_count),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_peak_count   (rsp_peak_count)
   );

   // The store is swept straight after reset, so no request is taken then.
   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> full)
      else $error("request side open during the reset sweep");

   // A queued command is never lost: a full queue is either being worked off
   // or handing its oldest command to the engine.
   a_queue_full_busy: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> (b_status.busy || q_pop))
      else $error("command queue full while the engine is idle");

   // The engine only takes a command from a queue that holds one.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("engine popped an empty command queue");

endmodule

/* test/hough_line_vote_accumulator_checker.sv */
// ----------------------------------------------------------------------------
// Hough line vote accumulator checker
// Watches the command, result and register channels of the accumulator. It
// keeps its own vote store, peak count, registers and trigonometry table,
// works out the result of every read command and compares each popped result
// with the oldest expected one.
// ----------------------------------------------------------------------------
module hough_line_vote_accumulator_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                full,
   input  logic [hlva_pkg::OP_W-1:0]           req_op,
   input  logic [hlva_pkg::COORD_W-1:0]        req_row,
   input  logic [hlva_pkg::COORD_W-1:0]        req_col,
   input  logic [hlva_pkg::PIXEL_W-1:0]        req_pixel_value,
   input  logic [hlva_pkg::ANGLE_IDX_W-1:0]    req_angle_index,
   input  logic [hlva_pkg::DIST_IDX_W-1:0]     req_distance_index,
   input  logic                                empty,
   input  logic                                pop,
   input  logic [hlva_pkg::CELL_COUNT_W-1:0]   rsp_cell_count,
   input  logic [hlva_pkg::SCALED_W-1:0]       rsp_scaled_value,
   input  logic [hlva_pkg::CELL_COUNT_W-1:0]   rsp_peak_count,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [hlva_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hlva_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  fail_count,
   output int                                  reads_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import hlva_pkg::*;

   localparam int ANGLES = DEF_NUM_ANGLES;
   localparam int BINS   = DEF_DIST_BINS;
   localparam int LIMIT  = DEF_MAX_DIM;
   localparam logic [CELL_COUNT_W-1:0] COUNT_TOP = '1;

   typedef struct {
      logic [CELL_COUNT_W-1:0] cell_count;
      logic [SCALED_W-1:0]     scaled_value;
      logic [CELL_COUNT_W-1:0] peak_count;
   } read_result_type;

   logic [CELL_COUNT_W-1:0] cell_votes[int];
   logic [CELL_COUNT_W-1:0] peak_votes;
   logic [THRESH_W-1:0]     threshold;
   logic [BIAS_W-1:0]       bias;
   logic [INV_SCALE_W-1:0]  inv_scale;
   longint                  cos_q14[ANGLES];
   longint                  sin_q14[ANGLES];
   read_result_type         read_results[$];

   function automatic longint taylor_q30(longint unsigned phi, int odd);
      longint unsigned phi_sq;
      longint unsigned term;
      longint          acc;
      phi_sq = (phi * phi) >> 30;
      term   = odd ? phi : 64'd1073741824;
      acc    = longint'(term);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * phi_sq) >> 30) / longint'((2*k - 1 + odd) * (2*k + odd));
         acc  = (k % 2) ? acc - longint'(term) : acc + longint'(term);
      end
      return acc;
   endfunction

   function automatic longint to_q14(longint v);
      if (v < 0) v = 0;
      if (v > 64'sd1073741824) v = 64'sd1073741824;
      return (v + 32768) >>> 16;
   endfunction

   initial begin
      longint unsigned phi;
      int m;
      for (int a = 0; a < ANGLES; a++) begin
         m   = (2*a > ANGLES) ? ANGLES - a : a;
         phi = 64'd3373259426 * longint'(m) / ANGLES;
         sin_q14[a] = to_q14(taylor_q30(phi, 1));
         cos_q14[a] = to_q14(taylor_q30(phi, 0));
         if (2*a > ANGLES) cos_q14[a] = -cos_q14[a];
      end
   end

   task automatic cast_votes(longint row, longint col);
      longint offset;
      longint scaled;
      int     key;
      for (int a = 0; a < ANGLES; a++) begin
         offset = row * cos_q14[a] + col * sin_q14[a] + longint'(bias) * 16384;
         scaled = offset * longint'(inv_scale);
         if (scaled >= 0 && (scaled >>> 22) < BINS) begin
            key = a * BINS + int'(scaled >>> 22);
            if (!cell_votes.exists(key)) cell_votes[key] = '0;
            if (cell_votes[key] != COUNT_TOP) cell_votes[key]++;
            if (cell_votes[key] > peak_votes) peak_votes = cell_votes[key];
         end
      end
   endtask

   function automatic read_result_type read_cell(int angle, int bin);
      read_result_type r;
      int key;
      key = angle * BINS + bin;
      r.cell_count = (cell_votes.exists(key)) ? cell_votes[key] : '0;
      r.peak_count = peak_votes;
      r.scaled_value = (peak_votes == 0) ? '0 :
                       SCALED_W'(longint'(r.cell_count) * 4095 / longint'(peak_votes));
      return r;
   endfunction

   always @(posedge clock) begin
      read_result_type got;
      read_result_type want;
      if (reset) begin
         cell_votes.delete();
         peak_votes = '0;
         threshold  = THRESH_RESET;
         bias       = BIAS_RESET;
         inv_scale  = INV_SCALE_RESET;
         read_results.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_THRESHOLD: threshold = csr_wdata[THRESH_W-1:0];
               CSR_BIAS:      bias = csr_wdata[BIAS_W-1:0];
               CSR_INV_SCALE: inv_scale = csr_wdata;
               default: ;
            endcase
         end
         if (pop && !empty) begin
            got.cell_count   = rsp_cell_count;
            got.scaled_value = rsp_scaled_value;
            got.peak_count   = rsp_peak_count;
            if (read_results.size() == 0) begin
               $display("%0t unexpected result: cell_count %0d scaled_value %0d peak_count %0d",
                        $time, got.cell_count, got.scaled_value, got.peak_count);
               fail_count++;
            end else begin
               want = read_results.pop_front();
               if (got.cell_count !== want.cell_count) begin
                  $display("%0t cell_count expected %0d actual %0d",
                           $time, want.cell_count, got.cell_count);
                  fail_count++;
               end
               if (got.scaled_value !== want.scaled_value) begin
                  $display("%0t scaled_value expected %0d actual %0d",
                           $time, want.scaled_value, got.scaled_value);
                  fail_count++;
               end
               if (got.peak_count !== want.peak_count) begin
                  $display("%0t peak_count expected %0d actual %0d",
                           $time, want.peak_count, got.peak_count);
                  fail_count++;
               end
            end
         end
         if (push && !full) begin
            case (op_type'(req_op))
               OP_VOTE: begin
                  if (req_pixel_value >= threshold && req_row < LIMIT && req_col < LIMIT)
                     cast_votes(req_row, req_col);
               end
               OP_READ: read_results.push_back(read_cell(req_angle_index, req_distance_index));
               OP_CLEAR: begin
                  cell_votes.delete();
                  peak_votes = '0;
               end
               default: ;
            endcase
         end
      end
      reads_pending = read_results.size();
   end

endmodule

/* test/hough_line_vote_accumulator_top_test.sv */
// ----------------------------------------------------------------------------
// Hough line vote accumulator testbench
// Drives vote, read, clear and undefined commands in bursts through several
// register settings, stalls the result side on its own pattern, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module hough_line_vote_accumulator_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hlva_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    push = 1'b0;
   logic                    full;
   logic [OP_W-1:0]         req_op = OP_NONE;
   logic [COORD_W-1:0]      req_row = '0;
   logic [COORD_W-1:0]      req_col = '0;
   logic [PIXEL_W-1:0]      req_pixel_value = '0;
   logic [ANGLE_IDX_W-1:0]  req_angle_index = '0;
   logic [DIST_IDX_W-1:0]   req_distance_index = '0;
   logic                    empty;
   logic                    pop = 1'b0;
   logic [CELL_COUNT_W-1:0] rsp_cell_count;
   logic [SCALED_W-1:0]     rsp_scaled_value;
   logic [CELL_COUNT_W-1:0] rsp_peak_count;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   int                      fail_count;
   int                      reads_pending;
   int                      burst_left = 0;
   int                      cycle_count = 0;
   logic [THRESH_W-1:0]     stim_threshold = THRESH_RESET;

   always #4 clock = ~clock;

   hough_line_vote_accumulator_top u_top (.*);

   hough_line_vote_accumulator_checker u_checker (.*);

   // The result side alternates between stretches of steady popping and
   // stretches of random or long stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 300) % 4)
         0: pop <= 1'b1;
         1: pop <= ($urandom_range(0, 3) != 0);
         2: pop <= ($urandom_range(0, 9) == 0);
         default: pop <= ((cycle_count % 40) > 30);
      endcase
   end

   task automatic send(op_type op, int row, int col, int pix, int angle, int bin,
                       bit last = 1'b0);
      push               <= 1'b1;
      req_op             <= op;
      req_row            <= COORD_W'(row);
      req_col            <= COORD_W'(col);
      req_pixel_value    <= PIXEL_W'(pix);
      req_angle_index    <= ANGLE_IDX_W'(angle);
      req_distance_index <= DIST_IDX_W'(bin);
      do @(posedge clock); while (full);
      if (burst_left > 0 && !last) begin
         burst_left--;
      end else begin
         push <= 1'b0;
         if (!last) begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(0, 20);
         end
      end
   endtask

   task automatic write_reg(csr_index_type idx, int data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle;
      send(OP_READ, 0, 0, 0, 0, 0, 1'b1);
      @(posedge clock);
      while (reads_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_items(int count);
      int kind;
      int bin;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         bin = ($urandom_range(0, 1)) ? $urandom_range(0, 40) : $urandom_range(0, 4095);
         if (kind < 45) begin
            send(OP_VOTE, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(stim_threshold, 4095), $urandom, $urandom);
         end else if (kind < 65) begin
            send(OP_VOTE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 4095), $urandom, $urandom);
         end else if (kind < 97) begin
            send(OP_READ, $urandom, $urandom, $urandom, $urandom_range(0, 255), bin);
         end else begin
            send(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic new_setting(int thr, int bias, int inv);
      settle();
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_BIAS, bias);
      write_reg(CSR_INV_SCALE, inv);
      stim_threshold = THRESH_W'(thr);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(OP_VOTE, 0, 0, 4095, 0, 0);
      send(OP_VOTE, 1023, 1023, 4095, 0, 0);
      send(OP_VOTE, 0, 0, 2047, 0, 0);
      send(OP_VOTE, 0, 0, 2048, 0, 0);
      send(OP_VOTE, 1023, 0, 4095, 0, 0);
      send(OP_VOTE, 0, 1023, 0, 0, 0);
      send(OP_NONE, 1023, 1023, 4095, 255, 4095);
      send(OP_READ, 0, 0, 0, 0, 1449);
      send(OP_READ, 0, 0, 0, 128, 1449);
      send(OP_READ, 0, 0, 0, 255, 4095);
      send(OP_READ, 1023, 1023, 4095, 0, 0);
      send(OP_CLEAR, 0, 0, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 0, 1449);
      send(OP_VOTE, 5, 7, 3000, 0, 0);
      send(OP_READ, 0, 0, 0, 0, 1454);

      random_items(220);
      new_setting(0, 0, 1);
      send(OP_VOTE, 0, 0, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 0, 0);
      random_items(220);
      new_setting(4095, 4095, 65535);
      send(OP_VOTE, 0, 0, 4094, 0, 0);
      send(OP_VOTE, 0, 0, 4095, 0, 0);
      send(OP_READ, 0, 0, 0, 64, 4095);
      random_items(220);
      new_setting(1000, 2000, 40);
      random_items(220);
      new_setting(2048, 1449, 256);
      random_items(220);

      push <= 1'b0;
      @(posedge clock);
      while (reads_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && reads_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #240_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
design/hlva_pkg.sv
design/hlva_front.sv
design/hlva_queue.sv
design/hlva_back.sv
design/hough_line_vote_accumulator_top.sv
test/hough_line_vote_accumulator_checker.sv
test/hough_line_vote_accumulator_top_test.sv
